[rtl/i2cbs_pkg.sv]
// i2cbs_pkg: shared types and constants for the i2c master bit sequencer
// no dependencies; used by i2cbs_step and i2c_master_bit_sequencer
package i2cbs_pkg;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6
   } cmd_type;

   localparam logic [15:0] HALF_RESET = 16'd50;
   localparam logic [2:0]  PHASE_IDLE = 3'd0;
   localparam logic [2:0]  PHASE_ONE  = 3'd1;
   localparam logic [2:0]  PHASE_TWO  = 3'd2;
   localparam logic [2:0]  PHASE_THREE = 3'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [2:0]  phase;
      logic [15:0] timer;
      logic [3:0]  bit_cnt;
      logic [7:0]  shreg;
      logic        scl;
      logic        sda;
      logic [7:0]  read_hold;
   } seq_state_type;

endpackage

[rtl/i2cbs_step.sv]
// i2cbs_step: next-state logic for one tick of the sequencer
// depends on i2cbs_pkg
module i2cbs_step
   import i2cbs_pkg::*;
(
   input  seq_state_type cur,
   input  req_type       req,
   input  logic [15:0]   half_period,
   output seq_state_type nxt,
   output logic          done
);

   logic [15:0] wait_load;
   logic [7:0]  shift_next;
   logic [3:0]  cnt_next;

   assign wait_load  = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
   assign shift_next = (cur.cmd == CMD_READ) ? {cur.shreg[6:0], req.sda_in}
                                             : {cur.shreg[6:0], 1'b0};
   assign cnt_next   = cur.bit_cnt + 4'd1;

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (cur.cmd == CMD_NONE) begin
         // launch a new command
         unique case (req.action) inside
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_ACK, CMD_NACK: begin
               nxt.cmd     = cmd_type'(req.action);
               nxt.phase   = PHASE_ONE;
               nxt.bit_cnt = 4'd0;
               nxt.timer   = wait_load;
               unique case (req.action)
                  CMD_START: begin
                     nxt.scl = 1'b0;
                     nxt.sda = 1'b1;
                  end
                  CMD_STOP: nxt.scl = 1'b0;
                  CMD_WRITE: begin
                     nxt.shreg = req.write_byte;
                     nxt.sda   = req.write_byte[7];
                  end
                  CMD_READ: begin
                     nxt.sda   = 1'b1;
                     nxt.shreg = 8'd0;
                  end
                  CMD_ACK: nxt.sda = 1'b0;
                  default: nxt.sda = 1'b1;
               endcase
            end
            default: nxt.cmd = CMD_NONE;
         endcase
      end else if (cur.timer != 16'd0) begin
         nxt.timer = cur.timer - 16'd1;
      end else begin
         unique case (cur.cmd) inside
            CMD_START, CMD_STOP: begin
               if (cur.phase == PHASE_ONE) begin
                  if (cur.cmd == CMD_START) nxt.scl = 1'b1;
                  else nxt.sda = 1'b0;
                  nxt.phase = PHASE_TWO;
                  nxt.timer = wait_load;
               end else if (cur.phase == PHASE_TWO) begin
                  if (cur.cmd == CMD_START) nxt.sda = 1'b0;
                  else nxt.scl = 1'b1;
                  nxt.phase = PHASE_THREE;
                  nxt.timer = wait_load;
               end else begin
                  if (cur.cmd == CMD_START) nxt.scl = 1'b0;
                  else nxt.sda = 1'b1;
                  nxt.cmd   = CMD_NONE;
                  nxt.phase = PHASE_IDLE;
                  nxt.timer = 16'd0;
                  done      = 1'b1;
               end
            end
            CMD_WRITE, CMD_READ, CMD_ACK, CMD_NACK: begin
               if (cur.phase == PHASE_ONE) begin
                  nxt.scl   = 1'b1;
                  nxt.phase = PHASE_TWO;
                  nxt.timer = wait_load;
               end else if (cur.cmd == CMD_WRITE || cur.cmd == CMD_READ) begin
                  nxt.scl     = 1'b0;
                  nxt.shreg   = shift_next;
                  nxt.bit_cnt = cnt_next;
                  if (cnt_next[3]) begin
                     // eighth bit shifted, command ends
                     if (cur.cmd == CMD_WRITE) nxt.sda = 1'b1;
                     else nxt.read_hold = shift_next;
                     nxt.cmd   = CMD_NONE;
                     nxt.phase = PHASE_IDLE;
                     nxt.timer = 16'd0;
                     done      = 1'b1;
                  end else begin
                     if (cur.cmd == CMD_WRITE) nxt.sda = shift_next[7];
                     nxt.phase = PHASE_ONE;
                     nxt.timer = wait_load;
                  end
               end else begin
                  // ack drops scl and releases sda, nack leaves scl high
                  if (cur.cmd == CMD_ACK) begin
                     nxt.scl = 1'b0;
                     nxt.sda = 1'b1;
                  end else begin
                     nxt.scl = 1'b1;
                  end
                  nxt.cmd   = CMD_NONE;
                  nxt.phase = PHASE_IDLE;
                  nxt.timer = 16'd0;
                  done      = 1'b1;
               end
            end
            default: nxt.cmd = CMD_NONE;
         endcase
      end
   end

endmodule

[rtl/i2c_master_bit_sequencer.sv]
// i2c_master_bit_sequencer: tick-driven i2c master pin sequencer, top level
// depends on i2cbs_pkg and i2cbs_step
//
//   port group   dir   carries
//   req_*        in    one tick: action, write_byte, sda_in
//   rsp_*        out   pin levels, busy, done, read byte after that tick
//   csr_*        in    half_period_ticks write
//
// one request per cycle while not stalled; each response comes next cycle
// sequencer state advances only when a request is accepted
// a single output register decouples the sides: req_stall rises only while
// that register is full and rsp_stall is high
// synchronous active-high reset: pins released, idle, half period 50
module i2c_master_bit_sequencer
   import i2cbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   seq_state_type state_ff, state_in;
   logic [15:0]   half_ff, half_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          done;
   logic          accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   i2cbs_step u_step (
      .cur         (state_ff),
      .req         (req_data),
      .half_period (half_ff),
      .nxt         (state_in),
      .done        (done)
   );

   // output valid register and half period register control
   always_comb begin
      half_in      = csr_we ? csr_wdata : half_ff;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   // response fields from the updated state
   always_comb begin
      rsp_data_in           = rsp_data_ff;
      if (accept) begin
         rsp_data_in.scl_out   = state_in.scl;
         rsp_data_in.sda_out   = state_in.sda;
         rsp_data_in.busy_res  = (state_in.cmd != CMD_NONE);
         rsp_data_in.done_res  = done;
         rsp_data_in.read_byte = state_in.read_hold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cmd       <= CMD_NONE;
         state_ff.phase     <= PHASE_IDLE;
         state_ff.timer     <= 16'd0;
         state_ff.bit_cnt   <= 4'd0;
         state_ff.shreg     <= 8'd0;
         state_ff.scl       <= 1'b1;
         state_ff.sda       <= 1'b1;
         state_ff.read_hold <= 8'd0;
         half_ff            <= HALF_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
